>>> design/hrhp_pkg.sv
package hrhp_pkg;

   // parse phases
   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_TARGET  = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;
   localparam logic [2:0] PH_ERROR   = 3'd6;
   localparam logic [2:0] PH_HALTED  = 3'd7;

   // field closed by a byte
   localparam logic [2:0] FE_NONE    = 3'd0;
   localparam logic [2:0] FE_METHOD  = 3'd1;
   localparam logic [2:0] FE_TARGET  = 3'd2;
   localparam logic [2:0] FE_VERSION = 3'd3;
   localparam logic [2:0] FE_KEY     = 3'd4;
   localparam logic [2:0] FE_VALUE   = 3'd5;
   localparam logic [2:0] FE_HEADERS = 3'd6;

   // sticky error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_METHOD  = 3'd1;
   localparam logic [2:0] ERR_NEWLINE     = 3'd2;
   localparam logic [2:0] ERR_NULL_HEADER = 3'd3;
   localparam logic [2:0] ERR_VER_SPACE   = 3'd4;
   localparam logic [2:0] ERR_BAD_VERSION = 3'd5;

   // status classes
   localparam logic [1:0] CLS_OK          = 2'd0;
   localparam logic [1:0] CLS_BAD_REQUEST = 2'd1;
   localparam logic [1:0] CLS_UNSUPPORTED = 2'd2;

   // special bytes
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_SP  = 8'h20;

   // method names, left aligned, padded with zero
   localparam int METHOD_COUNT     = 9;
   localparam int METHOD_NAME_MAX  = 7;
   localparam logic [7:0] METHOD_TEXT [METHOD_COUNT][METHOD_NAME_MAX] = '{
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S"},
      '{"D", "E", "L", "E", "T", "E", 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T"}
   };
   localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
      4'd5, 4'd4, 4'd3, 4'd4, 4'd5, 4'd3, 4'd7, 4'd6, 4'd7
   };

   // version names, all the same length
   localparam int VERSION_COUNT    = 3;
   localparam int VERSION_NAME_LEN = 8;
   localparam logic [7:0] VERSION_TEXT [VERSION_COUNT][VERSION_NAME_LEN] = '{
      '{"H", "T", "T", "P", "/", "1", ".", "0"},
      '{"H", "T", "T", "P", "/", "1", ".", "1"},
      '{"H", "T", "T", "P", "/", "2", ".", "0"}
   };

   // one result word
   typedef struct packed {
      logic [2:0]  parse_state;
      logic [2:0]  field_end;
      logic [2:0]  error_code;
      logic [1:0]  http_status_class;
      logic [3:0]  method_id;
      logic [1:0]  version_id;
      logic        is_body_byte;
      logic        request_ready;
      logic [11:0] byte_offset;
   } rsp_type;

endpackage

>>> design/hrhp_req_if.sv
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_request;

   modport source (output valid, output data_byte, output new_request, input ready);
   modport sink   (input valid, input data_byte, input new_request, output ready);
endinterface

>>> design/hrhp_rsp_if.sv
interface hrhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  parse_state;
   logic [2:0]  field_end;
   logic [2:0]  error_code;
   logic [1:0]  http_status_class;
   logic [3:0]  method_id;
   logic [1:0]  version_id;
   logic        is_body_byte;
   logic        request_ready;
   logic [11:0] byte_offset;

   modport source (
      output valid, output parse_state, output field_end, output error_code,
      output http_status_class, output method_id, output version_id,
      output is_body_byte, output request_ready, output byte_offset,
      input ready
   );
   modport sink (
      input valid, input parse_state, input field_end, input error_code,
      input http_status_class, input method_id, input version_id,
      input is_body_byte, input request_ready, input byte_offset,
      output ready
   );
endinterface

>>> design/hrhp_parser.sv
module hrhp_parser #(
   parameter int BUFFER_BYTES      = 4096,
   parameter int METHOD_MAX_CHARS  = 7,
   parameter int VERSION_MAX_CHARS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       data_byte,
   input  logic             new_request,
   output hrhp_pkg::rsp_type result
);
   import hrhp_pkg::*;

   localparam int OW  = $clog2(BUFFER_BYTES + 1);
   localparam int OX  = (OW > 12) ? OW : 12;
   localparam int MLW = $clog2(METHOD_MAX_CHARS + 2);
   localparam int MIW = $clog2(METHOD_MAX_CHARS);
   localparam int VLW = $clog2(VERSION_MAX_CHARS + 2);
   localparam int VIW = $clog2(VERSION_MAX_CHARS);

   // parse state
   logic [2:0]     phase_ff, phase_in;
   logic [7:0]     method_chars_ff [METHOD_MAX_CHARS];
   logic [MLW-1:0] method_len_ff, method_len_in;
   logic           method_sealed_ff, method_sealed_in;
   logic [7:0]     version_chars_ff [VERSION_MAX_CHARS];
   logic [VLW-1:0] version_len_ff, version_len_in;
   logic           version_sealed_ff, version_sealed_in;
   logic           line_has_text_ff, line_has_text_in;
   logic           value_at_start_ff, value_at_start_in;
   logic [2:0]     error_ff, error_in;
   logic [3:0]     method_found_ff, method_found_in;
   logic [1:0]     version_found_ff, version_found_in;
   logic [OW-1:0]  offset_ff, offset_in;

   // state as seen by this byte (cleared by new_request)
   logic [2:0]     cur_phase;
   logic [MLW-1:0] cur_mlen;
   logic           cur_msealed;
   logic [VLW-1:0] cur_vlen;
   logic           cur_vsealed;
   logic           cur_text;
   logic           cur_vas;
   logic [2:0]     cur_error;
   logic [3:0]     cur_mfound;
   logic [1:0]     cur_vfound;
   logic [OW-1:0]  pos;
   logic [OX-1:0]  pos_x;

   logic [3:0]     method_hit;
   logic [1:0]     version_hit;
   logic           method_we, version_we;
   logic [MIW-1:0] method_widx;
   logic [VIW-1:0] version_widx;
   logic [2:0]     fend;
   logic           body, ready;

   always_comb begin
      cur_phase   = new_request ? PH_METHOD : phase_ff;
      cur_mlen    = new_request ? '0 : method_len_ff;
      cur_msealed = new_request ? 1'b0 : method_sealed_ff;
      cur_vlen    = new_request ? '0 : version_len_ff;
      cur_vsealed = new_request ? 1'b0 : version_sealed_ff;
      cur_text    = new_request ? 1'b0 : line_has_text_ff;
      cur_vas     = new_request ? 1'b0 : value_at_start_ff;
      cur_error   = new_request ? ERR_NONE : error_ff;
      cur_mfound  = new_request ? 4'd0 : method_found_ff;
      cur_vfound  = new_request ? 2'd0 : version_found_ff;
      pos         = new_request ? '0 : offset_ff;
      pos_x       = OX'(pos);
   end

   // parallel compare of the stored method against the fixed names
   always_comb begin
      logic ok;
      method_hit = 4'd0;
      for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
         ok = (cur_mlen == MLW'(METHOD_LEN[i]));
         for (int j = 0; j < METHOD_NAME_MAX; j++) begin
            if (4'(j) < METHOD_LEN[i]) begin
               ok = ok && (method_chars_ff[j] == METHOD_TEXT[i][j]);
            end
         end
         if (ok) begin
            method_hit = 4'(i + 1);
         end
      end
   end

   // parallel compare of the stored version against the fixed names
   always_comb begin
      logic ok;
      version_hit = 2'd0;
      for (int i = VERSION_COUNT - 1; i >= 0; i--) begin
         ok = (cur_vlen == VLW'(VERSION_NAME_LEN));
         for (int j = 0; j < VERSION_NAME_LEN; j++) begin
            ok = ok && (version_chars_ff[j] == VERSION_TEXT[i][j]);
         end
         if (ok) begin
            version_hit = 2'(i + 1);
         end
      end
   end

   // byte classification and phase walk
   always_comb begin
      phase_in          = cur_phase;
      method_len_in     = cur_mlen;
      method_sealed_in  = cur_msealed;
      version_len_in    = cur_vlen;
      version_sealed_in = cur_vsealed;
      line_has_text_in  = cur_text;
      value_at_start_in = cur_vas;
      error_in          = cur_error;
      method_found_in   = cur_mfound;
      version_found_in  = cur_vfound;
      offset_in         = (pos < OW'(BUFFER_BYTES)) ? pos + OW'(1) : pos;
      method_we         = 1'b0;
      version_we        = 1'b0;
      fend              = FE_NONE;
      body              = 1'b0;
      ready             = 1'b0;

      if (pos >= OW'(BUFFER_BYTES) && cur_phase < PH_ERROR) begin
         phase_in = PH_HALTED;
      end else if (cur_phase == PH_BODY) begin
         body = 1'b1;
      end else if (cur_phase < PH_BODY) begin
         if (data_byte == CHAR_NUL) begin
            phase_in = PH_HALTED;
         end else if (data_byte == CHAR_CR) begin
            // seal the method or version field; in a value, clear value_at_start
            if (cur_phase == PH_METHOD) begin
               method_sealed_in = 1'b1;
            end else if (cur_phase == PH_VERSION) begin
               version_sealed_in = 1'b1;
            end else if (cur_phase == PH_VALUE) begin
               value_at_start_in = 1'b0;
            end
         end else if (data_byte == CHAR_SP) begin
            case (cur_phase)
               PH_METHOD: begin
                  fend            = FE_METHOD;
                  method_found_in = method_hit;
                  if (method_hit == 4'd0) begin
                     error_in = ERR_BAD_METHOD;
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in = PH_TARGET;
                  end
               end
               PH_TARGET: begin
                  fend     = FE_TARGET;
                  phase_in = PH_VERSION;
               end
               PH_VERSION: begin
                  error_in = ERR_VER_SPACE;
                  phase_in = PH_ERROR;
               end
               PH_KEY: begin
                  fend              = FE_KEY;
                  phase_in          = PH_VALUE;
                  value_at_start_in = 1'b1;
               end
               default: begin
                  // space inside a value: no state changes
               end
            endcase
         end else if (data_byte == CHAR_LF) begin
            case (cur_phase)
               PH_VERSION: begin
                  fend             = FE_VERSION;
                  version_found_in = version_hit;
                  if (version_hit == 2'd0) begin
                     error_in = ERR_BAD_VERSION;
                     phase_in = PH_ERROR;
                  end else begin
                     phase_in         = PH_KEY;
                     line_has_text_in = 1'b0;
                  end
               end
               PH_KEY: begin
                  if (!cur_text) begin
                     fend     = FE_HEADERS;
                     ready    = 1'b1;
                     phase_in = PH_BODY;
                  end else begin
                     error_in = ERR_NULL_HEADER;
                     phase_in = PH_ERROR;
                  end
               end
               PH_VALUE: begin
                  fend              = FE_VALUE;
                  phase_in          = PH_KEY;
                  line_has_text_in  = 1'b0;
                  value_at_start_in = 1'b0;
               end
               default: begin
                  error_in = ERR_NEWLINE;
                  phase_in = PH_ERROR;
               end
            endcase
         end else begin
            // ordinary byte
            if (cur_phase == PH_METHOD) begin
               if (!cur_msealed) begin
                  if (cur_mlen < MLW'(METHOD_MAX_CHARS)) begin
                     method_we     = 1'b1;
                     method_len_in = cur_mlen + MLW'(1);
                  end else begin
                     method_len_in = MLW'(METHOD_MAX_CHARS + 1);
                  end
               end
            end else if (cur_phase == PH_VERSION) begin
               if (!cur_vsealed) begin
                  if (cur_vlen < VLW'(VERSION_MAX_CHARS)) begin
                     version_we     = 1'b1;
                     version_len_in = cur_vlen + VLW'(1);
                  end else begin
                     version_len_in = VLW'(VERSION_MAX_CHARS + 1);
                  end
               end
            end else if (cur_phase == PH_KEY) begin
               line_has_text_in = 1'b1;
            end else if (cur_phase == PH_VALUE) begin
               value_at_start_in = 1'b0;
            end
         end
      end
   end

   assign method_widx  = cur_mlen[MIW-1:0];
   assign version_widx = cur_vlen[VIW-1:0];

   // result word for this byte
   always_comb begin
      result.parse_state = phase_in;
      result.field_end   = fend;
      result.error_code  = error_in;
      if (error_in == ERR_NONE) begin
         result.http_status_class = CLS_OK;
      end else if (error_in <= ERR_NULL_HEADER) begin
         result.http_status_class = CLS_BAD_REQUEST;
      end else begin
         result.http_status_class = CLS_UNSUPPORTED;
      end
      result.method_id     = method_found_in;
      result.version_id    = version_found_in;
      result.is_body_byte  = body;
      result.request_ready = ready;
      result.byte_offset   = (pos_x > OX'(4095)) ? 12'hfff : pos_x[11:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_METHOD;
         method_len_ff     <= '0;
         method_sealed_ff  <= 1'b0;
         version_len_ff    <= '0;
         version_sealed_ff <= 1'b0;
         line_has_text_ff  <= 1'b0;
         value_at_start_ff <= 1'b0;
         error_ff          <= ERR_NONE;
         method_found_ff   <= 4'd0;
         version_found_ff  <= 2'd0;
         offset_ff         <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         method_len_ff     <= method_len_in;
         method_sealed_ff  <= method_sealed_in;
         version_len_ff    <= version_len_in;
         version_sealed_ff <= version_sealed_in;
         line_has_text_ff  <= line_has_text_in;
         value_at_start_ff <= value_at_start_in;
         error_ff          <= error_in;
         method_found_ff   <= method_found_in;
         version_found_ff  <= version_found_in;
         offset_ff         <= offset_in;
      end
   end

   // name character stores, read only below their lengths
   always_ff @(posedge clock) begin
      for (int k = 0; k < METHOD_MAX_CHARS; k++) begin
         if (step && method_we && method_widx == MIW'(k)) begin
            method_chars_ff[k] <= data_byte;
         end
      end
      for (int k = 0; k < VERSION_MAX_CHARS; k++) begin
         if (step && version_we && version_widx == VIW'(k)) begin
            version_chars_ff[k] <= data_byte;
         end
      end
   end

endmodule

>>> design/hrhp_out_buf.sv
module hrhp_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrhp_pkg::rsp_type push_word,
   output logic              can_push,
   output logic              head_valid,
   output hrhp_pkg::rsp_type head_word,
   input  logic              pop
);
   import hrhp_pkg::*;

   // two-entry result queue
   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign can_push   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_word  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry write
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> design/http_request_head_parser_core.sv
// HTTP request head parser, one byte per word.
// req_chan carries one request byte (data_byte) and a new_request flag that
// clears all parse state ahead of that byte. rsp_chan returns exactly one
// result word per accepted byte: phase, closed field, sticky error code and
// status class, matched method and version, body and head-done flags, and
// the saturating byte position.
// The result of a byte is written into a two-word output queue as the byte
// is accepted and shown on rsp_chan once the words ahead of it have left.
// Throughput: one byte per cycle while the queue has room; all parsing,
// including the parallel name compares, is done in the cycle the byte is taken.
// When the receiver stalls, bytes are still accepted until both queue
// entries hold a word; then req_chan.ready drops, and it rises again the
// cycle after a word leaves. No result is dropped or repeated.
// Reset (synchronous, active high) empties the queue and returns the parser
// to the method phase with no error; there is no clearing pass, the block
// is ready in the first cycle after reset.
module http_request_head_parser_core #(
   parameter int BUFFER_BYTES      = 4096,
   parameter int METHOD_MAX_CHARS  = 7,
   parameter int VERSION_MAX_CHARS = 8
) (
   input logic         clock,
   input logic         reset,
   hrhp_req_if.sink    req_chan,
   hrhp_rsp_if.source  rsp_chan
);
   import hrhp_pkg::*;

   logic    step;
   logic    can_push;
   logic    head_valid;
   rsp_type result;
   rsp_type head_word;

   assign req_chan.ready = can_push;
   assign step           = req_chan.valid && can_push;

   // byte parser
   hrhp_parser #(
      .BUFFER_BYTES      (BUFFER_BYTES),
      .METHOD_MAX_CHARS  (METHOD_MAX_CHARS),
      .VERSION_MAX_CHARS (VERSION_MAX_CHARS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (req_chan.data_byte),
      .new_request (req_chan.new_request),
      .result      (result)
   );

   // result queue
   hrhp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .push_word  (result),
      .can_push   (can_push),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop        (rsp_chan.ready)
   );

   // drive the result channel
   assign rsp_chan.valid             = head_valid;
   assign rsp_chan.parse_state       = head_word.parse_state;
   assign rsp_chan.field_end         = head_word.field_end;
   assign rsp_chan.error_code        = head_word.error_code;
   assign rsp_chan.http_status_class = head_word.http_status_class;
   assign rsp_chan.method_id         = head_word.method_id;
   assign rsp_chan.version_id        = head_word.version_id;
   assign rsp_chan.is_body_byte      = head_word.is_body_byte;
   assign rsp_chan.request_ready     = head_word.request_ready;
   assign rsp_chan.byte_offset       = head_word.byte_offset;

endmodule

>>> tb/hrhp_head_checker.sv
module hrhp_head_checker (
   input  logic clock,
   input  logic reset,
   hrhp_req_if  req_mon,
   hrhp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   words_pending,
   output int   words_checked,
   output int   heads_done
);
   timeunit 1ns;
   timeprecision 1ps;
   import hrhp_pkg::*;

   localparam int BUFFER_LIMIT = 4096;
   localparam int METHOD_CAP   = 7;
   localparam int VERSION_CAP  = 8;

   string known_methods [$] = '{"TRACE", "HEAD", "GET", "POST", "PATCH", "PUT",
                                "OPTIONS", "DELETE", "CONNECT"};
   string known_versions [$] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};

   // parser state as seen from outside
   logic [2:0]  stage;
   logic [7:0]  meth_buf [8];
   logic [3:0]  meth_count;
   logic        meth_closed;
   logic [7:0]  ver_buf [8];
   logic [3:0]  ver_count;
   logic        ver_closed;
   logic        key_seen_text;
   logic        lead_window;
   logic [2:0]  held_error;
   logic [3:0]  meth_match;
   logic [1:0]  ver_match;
   logic [12:0] byte_pos;

   rsp_type expected_words [$];

   function automatic void clear_parse();
      stage         = PH_METHOD;
      meth_count    = 4'd0;
      meth_closed   = 1'b0;
      ver_count     = 4'd0;
      ver_closed    = 1'b0;
      key_seen_text = 1'b0;
      lead_window   = 1'b0;
      held_error    = ERR_NONE;
      meth_match    = 4'd0;
      ver_match     = 2'd0;
      byte_pos      = 13'd0;
      foreach (meth_buf[i]) meth_buf[i] = 8'd0;
      foreach (ver_buf[i]) ver_buf[i] = 8'd0;
   endfunction

   // index 1.. of the name equal to the stored field, 0 when none
   function automatic logic [3:0] name_index(input logic [7:0] chars [8],
                                             input logic [3:0] count,
                                             input string names [$]);
      string entry;
      logic  same;
      foreach (names[n]) begin
         entry = names[n];
         if (int'(count) == entry.len()) begin
            same = 1'b1;
            for (int c = 0; c < entry.len(); c++)
               if (chars[c] != entry[c]) same = 1'b0;
            if (same) return 4'(n + 1);
         end
      end
      return 4'd0;
   endfunction

   // advance the parser by one byte and form its result word
   function automatic rsp_type predict_word(input logic [7:0] b, input logic fresh);
      rsp_type     w;
      logic [12:0] pos;
      logic [2:0]  closed;
      logic        body;
      logic        done;
      if (fresh) clear_parse();
      pos = byte_pos;
      if (byte_pos < BUFFER_LIMIT) byte_pos++;
      closed = FE_NONE;
      body   = 1'b0;
      done   = 1'b0;
      if (pos >= BUFFER_LIMIT && stage < PH_ERROR) begin
         stage = PH_HALTED;
      end else if (stage == PH_BODY) begin
         body = 1'b1;
      end else if (stage < PH_BODY) begin
         if (b == CHAR_NUL) begin
            stage = PH_HALTED;
         end else if (b == CHAR_CR) begin
            // seals the field in progress, phase stays
            if (stage == PH_METHOD) meth_closed = 1'b1;
            else if (stage == PH_VERSION) ver_closed = 1'b1;
            else if (stage == PH_VALUE) lead_window = 1'b0;
         end else if (b == CHAR_SP) begin
            case (stage)
               PH_METHOD: begin
                  closed = FE_METHOD;
                  meth_match = name_index(meth_buf, meth_count, known_methods);
                  if (meth_match == 4'd0) begin
                     held_error = ERR_BAD_METHOD;
                     stage      = PH_ERROR;
                  end else begin
                     stage = PH_TARGET;
                  end
               end
               PH_TARGET: begin
                  closed = FE_TARGET;
                  stage  = PH_VERSION;
               end
               PH_VERSION: begin
                  held_error = ERR_VER_SPACE;
                  stage      = PH_ERROR;
               end
               PH_KEY: begin
                  closed      = FE_KEY;
                  stage       = PH_VALUE;
                  lead_window = 1'b1;
               end
               default: ;
            endcase
         end else if (b == CHAR_LF) begin
            case (stage)
               PH_VERSION: begin
                  closed    = FE_VERSION;
                  ver_match = 2'(name_index(ver_buf, ver_count, known_versions));
                  if (ver_match == 2'd0) begin
                     held_error = ERR_BAD_VERSION;
                     stage      = PH_ERROR;
                  end else begin
                     stage         = PH_KEY;
                     key_seen_text = 1'b0;
                  end
               end
               PH_KEY: begin
                  if (!key_seen_text) begin
                     closed = FE_HEADERS;
                     done   = 1'b1;
                     stage  = PH_BODY;
                  end else begin
                     held_error = ERR_NULL_HEADER;
                     stage      = PH_ERROR;
                  end
               end
               PH_VALUE: begin
                  closed        = FE_VALUE;
                  stage         = PH_KEY;
                  key_seen_text = 1'b0;
                  lead_window   = 1'b0;
               end
               default: begin
                  held_error = ERR_NEWLINE;
                  stage      = PH_ERROR;
               end
            endcase
         end else begin
            // ordinary byte: stored until the field is sealed or overflows
            case (stage)
               PH_METHOD: begin
                  if (!meth_closed) begin
                     if (meth_count < METHOD_CAP) begin
                        meth_buf[meth_count] = b;
                        meth_count++;
                     end else begin
                        meth_count = 4'(METHOD_CAP + 1);
                     end
                  end
               end
               PH_VERSION: begin
                  if (!ver_closed) begin
                     if (ver_count < VERSION_CAP) begin
                        ver_buf[ver_count] = b;
                        ver_count++;
                     end else begin
                        ver_count = 4'(VERSION_CAP + 1);
                     end
                  end
               end
               PH_KEY:   key_seen_text = 1'b1;
               PH_VALUE: lead_window = 1'b0;
               default: ;
            endcase
         end
      end
      w.parse_state       = stage;
      w.field_end         = closed;
      w.error_code        = held_error;
      w.http_status_class = (held_error == ERR_NONE) ? CLS_OK :
                            (held_error <= ERR_NULL_HEADER) ? CLS_BAD_REQUEST :
                            CLS_UNSUPPORTED;
      w.method_id         = meth_match;
      w.version_id        = ver_match;
      w.is_body_byte      = body;
      w.request_ready     = done;
      w.byte_offset       = (pos > 13'd4095) ? 12'hfff : pos[11:0];
      return w;
   endfunction

   function automatic void check_field(input string field, input logic [11:0] want,
                                       input logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // predict on each accepted byte, compare on each accepted word
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parse();
         expected_words.delete();
         mismatch_count = 0;
         words_checked  = 0;
         heads_done     = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(predict_word(req_mon.data_byte, req_mon.new_request));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("result word arrived with none expected");
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("parse_state", 12'(want.parse_state),
                           12'(rsp_mon.parse_state));
               check_field("field_end", 12'(want.field_end), 12'(rsp_mon.field_end));
               check_field("error_code", 12'(want.error_code), 12'(rsp_mon.error_code));
               check_field("http_status_class", 12'(want.http_status_class),
                           12'(rsp_mon.http_status_class));
               check_field("method_id", 12'(want.method_id), 12'(rsp_mon.method_id));
               check_field("version_id", 12'(want.version_id), 12'(rsp_mon.version_id));
               check_field("is_body_byte", 12'(want.is_body_byte),
                           12'(rsp_mon.is_body_byte));
               check_field("request_ready", 12'(want.request_ready),
                           12'(rsp_mon.request_ready));
               check_field("byte_offset", want.byte_offset, rsp_mon.byte_offset);
               words_checked++;
               if (want.request_ready) heads_done++;
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

>>> tb/tb_http_request_head_parser_core.sv
module tb_http_request_head_parser_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hrhp_pkg::*;

   localparam int RANDOM_BYTES = 1520;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_THROTTLE} rx_mode_type;

   string method_names [9] = '{"TRACE", "HEAD", "GET", "POST", "PATCH", "PUT",
                               "OPTIONS", "DELETE", "CONNECT"};
   string version_names [3] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   words_pending;
   int   words_checked;
   int   heads_done;
   int   cycle_count   = 0;
   int   bytes_sent    = 0;
   int   requests_sent = 0;
   int   random_bytes  = 0;
   int   burst_left    = 0;
   logic steady        = 1'b0;
   logic [7:0] request_bytes [$];

   hrhp_req_if req_bus ();
   hrhp_rsp_if rsp_bus ();

   http_request_head_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   hrhp_head_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked),
      .heads_done     (heads_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side stalls in modes of random length
   initial begin
      rx_mode_type rx_mode;
      int          left;
      int          tick;
      rsp_bus.ready = 1'b0;
      rx_mode = RX_OPEN;
      left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 200);
         end
         left--;
         tick++;
         case (rx_mode)
            RX_OPEN:    rsp_bus.ready <= 1'b1;
            RX_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_bus.ready <= ((tick % 5) < 3);
            default:    rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CHAR_LF || c == CHAR_CR || c == CHAR_SP);
      return c;
   endfunction

   function automatic logic [7:0] odd_byte();
      case ($urandom_range(0, 4))
         0:       return CHAR_NUL;
         1:       return CHAR_LF;
         2:       return CHAR_SP;
         3:       return CHAR_CR;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
   endfunction

   function automatic void add_line_end();
      if ($urandom_range(0, 1) == 0) request_bytes.push_back(CHAR_CR);
      request_bytes.push_back(CHAR_LF);
   endfunction

   // cr then a few bytes that must not reach the stored field
   function automatic void add_sealed_tail();
      request_bytes.push_back(CHAR_CR);
      repeat ($urandom_range(0, 2)) request_bytes.push_back(plain_char());
   endfunction

   // near miss of a known name
   function automatic void add_mangled(input string name);
      int spot;
      spot = $urandom_range(0, name.len() - 1);
      case ($urandom_range(0, 3))
         0:       name.putc(spot, byte'(name[spot] ^ 8'h20));
         1:       name = name.substr(0, name.len() - 2);
         2:       name = {name, "X"};
         default: name.putc(spot, byte'(plain_char()));
      endcase
      add_text(name);
   endfunction

   // mostly well formed request with random content, some broken
   function automatic void build_request();
      int pick;
      int spot;
      int keep;
      request_bytes.delete();
      if ($urandom_range(0, 24) == 0) begin
         repeat ($urandom_range(1, 10)) request_bytes.push_back(odd_byte());
         return;
      end
      // method
      pick = $urandom_range(0, 9);
      if (pick < 8) add_text(method_names[$urandom_range(0, 8)]);
      else if (pick == 8) add_mangled(method_names[$urandom_range(0, 8)]);
      else repeat ($urandom_range(0, 9)) request_bytes.push_back(plain_char());
      if ($urandom_range(0, 11) == 0) add_sealed_tail();
      request_bytes.push_back(CHAR_SP);
      // target
      repeat ($urandom_range(0, 5)) request_bytes.push_back(plain_char());
      request_bytes.push_back(CHAR_SP);
      // version
      if ($urandom_range(0, 6) != 0) add_text(version_names[$urandom_range(0, 2)]);
      else add_mangled(version_names[$urandom_range(0, 2)]);
      if ($urandom_range(0, 9) == 0) add_sealed_tail();
      add_line_end();
      // header lines
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(0, 4)) request_bytes.push_back(plain_char());
         request_bytes.push_back(CHAR_SP);
         repeat ($urandom_range(0, 2)) request_bytes.push_back(CHAR_SP);
         if ($urandom_range(0, 5) == 0) begin
            request_bytes.push_back(CHAR_CR);
            request_bytes.push_back(CHAR_SP);
         end
         repeat ($urandom_range(0, 5))
            request_bytes.push_back(($urandom_range(0, 3) == 0) ? CHAR_SP : plain_char());
         add_line_end();
      end
      // blank line, then a short body
      if ($urandom_range(0, 3) == 0) request_bytes.push_back(CHAR_CR);
      add_line_end();
      repeat ($urandom_range(0, 6)) request_bytes.push_back(8'($urandom));
      // damage one byte and cut the rest short
      if ($urandom_range(0, 4) == 0) begin
         spot = $urandom_range(1, request_bytes.size() - 1);
         request_bytes[spot] = odd_byte();
         keep = spot + 1 + $urandom_range(0, 3);
         while (request_bytes.size() > keep) void'(request_bytes.pop_back());
      end
   endfunction

   // one byte on the request channel, sent in bursts with gaps between unless steady
   task automatic push_byte(input logic [7:0] b, input logic fresh);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_bus.valid     <= 1'b0;
            req_bus.data_byte <= 8'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.new_request <= fresh;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_request(input logic fresh);
      steady = ($urandom_range(0, 5) == 0);
      requests_sent++;
      foreach (request_bytes[i]) push_byte(request_bytes[i], (i == 0) ? fresh : 1'b0);
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'd0;
      req_bus.new_request = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // cr sealing the version, leading and trailing value spaces, cr-only blank line,
      // nul and all-ones bytes in the body
      request_bytes.delete();
      add_text("GET / HTTP/1.1\015\nk:  v \015\n\015\n");
      request_bytes.push_back(CHAR_NUL);
      request_bytes.push_back(8'hff);
      send_request(1'b1);

      while (random_bytes < RANDOM_BYTES) begin
         build_request();
         send_request($urandom_range(0, 19) != 0);
         random_bytes += request_bytes.size();
      end
      req_bus.valid <= 1'b0;

      wait (words_pending == 0);
      repeat (4) @(negedge clock);
      $display("%0d bytes in %0d requests, %0d result words checked",
               bytes_sent, requests_sent, words_checked);
      $display("%0d heads completed under random bursts and receiver stalls", heads_done);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
